// ----- rtl/core/cbmt_pkg.sv -----
package cbmt_pkg;

  localparam int DEF_COUNTERS   = 1024;
  localparam int DEF_COUNT_BITS = 16;

  localparam int CFG_W       = 11;
  localparam int IDX_FIELD_W = 10;
  localparam int VAL_FIELD_W = 16;
  localparam int HOLD_W      = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [1:0] {
    REQ_INC  = 2'd0,
    REQ_DEC  = 2'd1,
    REQ_ZERO = 2'd2,
    REQ_READ = 2'd3
  } req_op_t;

  typedef struct packed {
    req_op_t                req_type;
    logic [IDX_FIELD_W-1:0] counter_index;
  } req_t;

  typedef struct packed {
    logic signed [VAL_FIELD_W-1:0] counter_value;
    logic signed [VAL_FIELD_W-1:0] max_value;
    logic [HOLD_W-1:0]             max_holders;
    logic                          bad_index;
    logic                          saturated;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic commit;
    logic scan_start;
    logic scan_issue;
    logic clear_step;
    logic out_load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic clear_last;
  } sts_t;

endpackage

// ----- rtl/core/cbmt_ifs.sv -----
interface cbmt_req_if;
  logic           valid;
  logic           ready;
  cbmt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbmt_rsp_if;
  logic           valid;
  logic           ready;
  cbmt_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbmt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cbmt_pkg::CFG_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/cbmt_ram.sv -----
module cbmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/cbmt_ctrl.sv -----
module cbmt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic           cfg_fire,
  input  cbmt_pkg::sts_t sts,
  output cbmt_pkg::cmd_t cmd
);

  cbmt_pkg::state_t state_r, state_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             out_free;

  assign out_free  = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cbmt_pkg::ST_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      cbmt_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = cbmt_pkg::ST_IDLE;
        end
      end
      cbmt_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = cbmt_pkg::ST_CALC;
        end
      end
      cbmt_pkg::ST_CALC: begin
        cmd.commit     = 1'b1;
        cmd.scan_start = sts.need_scan;
        state_nxt      = sts.need_scan ? cbmt_pkg::ST_SCAN : cbmt_pkg::ST_DONE;
      end
      cbmt_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = cbmt_pkg::ST_TAIL;
        end
      end
      cbmt_pkg::ST_TAIL: begin
        // last read of the sweep lands here
        state_nxt = cbmt_pkg::ST_DONE;
      end
      cbmt_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          in_ready     = 1'b1;
          cmd.accept   = in_valid;
          state_nxt    = in_valid ? cbmt_pkg::ST_CALC : cbmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cbmt_pkg::ST_CLEAR;
      end
    endcase
    if (cfg_fire) begin
      state_nxt = cbmt_pkg::ST_CLEAR;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

endmodule

// ----- rtl/core/cbmt_dp.sv -----
module cbmt_dp #(
  parameter int COUNTERS   = cbmt_pkg::DEF_COUNTERS,
  parameter int COUNT_BITS = cbmt_pkg::DEF_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cbmt_pkg::cmd_t             cmd,
  output cbmt_pkg::sts_t             sts,
  input  cbmt_pkg::req_t             in_data,
  input  logic                       cfg_fire,
  input  logic [cbmt_pkg::CFG_W-1:0] cfg_data,
  output cbmt_pkg::rsp_t             out_data
);

  localparam int IDX_W = $clog2(COUNTERS);
  localparam int CNT_W = $clog2(COUNTERS + 1);

  typedef logic signed [COUNT_BITS-1:0] val_t;

  localparam val_t VMAX = val_t'({1'b0, {(COUNT_BITS - 1){1'b1}}});
  localparam val_t VMIN = val_t'({1'b1, {(COUNT_BITS - 1){1'b0}}});

  // register value zero counts as one, above the bank size as the bank size
  function automatic logic [CNT_W-1:0] active_of(input logic [cbmt_pkg::CFG_W-1:0] v);
    logic [CNT_W-1:0] a;
    if (v == '0) begin
      a = CNT_W'(1);
    end else if (32'(v) > 32'(COUNTERS)) begin
      a = CNT_W'(COUNTERS);
    end else begin
      a = CNT_W'(v);
    end
    return a;
  endfunction

  logic [cbmt_pkg::CFG_W-1:0] cfg_r;
  cbmt_pkg::req_op_t          op_r;
  logic [IDX_W-1:0]           idx_r;
  logic                       bad_r;
  val_t                       max_r;
  logic [CNT_W-1:0]           holders_r;
  val_t                       res_val_r;
  logic                       res_bad_r;
  logic                       res_sat_r;
  logic [IDX_W-1:0]           scan_addr_r;
  logic [IDX_W-1:0]           clr_addr_r;
  logic                       acc_vld_r;
  logic                       acc_first_r;
  cbmt_pkg::rsp_t             out_r;

  logic [CNT_W-1:0]           active;
  logic [IDX_W-1:0]           last_addr;
  logic                       bad_in;
  logic [IDX_W-1:0]           ram_raddr;
  logic [IDX_W-1:0]           ram_waddr;
  logic [COUNT_BITS-1:0]      ram_wdata;
  logic [COUNT_BITS-1:0]      ram_rdata;
  logic                       ram_we;
  val_t                       cur;
  val_t                       val_nxt;
  logic                       sat_nxt;
  val_t                       max_nxt;
  logic [CNT_W-1:0]           holders_nxt;

  assign active    = active_of(cfg_r);
  assign last_addr = IDX_W'(active - CNT_W'(1));
  assign bad_in    = 32'(in_data.counter_index) >= 32'(active);
  assign cur       = val_t'(ram_rdata);

  always_comb begin
    val_nxt = cur;
    sat_nxt = 1'b0;
    unique case (op_r)
      cbmt_pkg::REQ_INC: begin
        if (cur == VMAX) begin
          sat_nxt = 1'b1;
        end else begin
          val_nxt = cur + val_t'(1);
        end
      end
      cbmt_pkg::REQ_DEC: begin
        if (cur == VMIN) begin
          sat_nxt = 1'b1;
        end else begin
          val_nxt = cur - val_t'(1);
        end
      end
      cbmt_pkg::REQ_ZERO: val_nxt = '0;
      cbmt_pkg::REQ_READ: val_nxt = cur;
      default:            val_nxt = cur;
    endcase
  end

  // incremental max update; losing the only holder forces a sweep
  always_comb begin
    max_nxt     = max_r;
    holders_nxt = holders_r;
    priority if (val_nxt > max_r) begin
      max_nxt     = val_nxt;
      holders_nxt = CNT_W'(1);
    end else if (val_nxt == max_r && cur != max_r) begin
      holders_nxt = CNT_W'(holders_r + CNT_W'(1));
    end else if (cur == max_r && val_nxt != max_r) begin
      holders_nxt = CNT_W'(holders_r - CNT_W'(1));
    end else begin
      holders_nxt = holders_r;
    end
  end

  assign sts.need_scan  = !bad_r && cur == max_r && val_nxt != max_r
                          && holders_r == CNT_W'(1);
  assign sts.scan_last  = scan_addr_r == last_addr;
  assign sts.clear_last = clr_addr_r == last_addr;

  assign ram_raddr = cmd.scan_issue ? scan_addr_r : IDX_W'(in_data.counter_index);
  assign ram_waddr = cmd.clear_step ? clr_addr_r : idx_r;
  assign ram_wdata = cmd.clear_step ? '0 : COUNT_BITS'(val_nxt);
  assign ram_we    = cmd.clear_step || (cmd.commit && !bad_r);

  cbmt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (COUNTERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= cbmt_pkg::CFG_RESET;
      max_r       <= '0;
      holders_r   <= active_of(cbmt_pkg::CFG_RESET);
      clr_addr_r  <= '0;
      scan_addr_r <= '0;
      acc_vld_r   <= 1'b0;
      acc_first_r <= 1'b0;
    end else begin
      acc_vld_r <= cmd.scan_issue;

      if (cfg_fire) begin
        cfg_r      <= cfg_data;
        clr_addr_r <= '0;
      end else if (cmd.clear_step) begin
        clr_addr_r <= clr_addr_r + IDX_W'(1);
      end

      if (cmd.scan_start) begin
        scan_addr_r <= '0;
      end else if (cmd.scan_issue) begin
        scan_addr_r <= scan_addr_r + IDX_W'(1);
      end

      if (cmd.scan_start) begin
        acc_first_r <= 1'b1;
      end else if (acc_vld_r) begin
        acc_first_r <= 1'b0;
      end

      if (cfg_fire) begin
        max_r     <= '0;
        holders_r <= active_of(cfg_data);
      end else if (cmd.commit && !bad_r) begin
        max_r     <= max_nxt;
        holders_r <= holders_nxt;
      end else if (acc_vld_r) begin
        if (acc_first_r || cur > max_r) begin
          max_r     <= cur;
          holders_r <= CNT_W'(1);
        end else if (cur == max_r) begin
          holders_r <= CNT_W'(holders_r + CNT_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_data.req_type;
      idx_r <= IDX_W'(in_data.counter_index);
      bad_r <= bad_in;
    end
    if (cmd.commit) begin
      res_val_r <= bad_r ? val_t'(0) : val_nxt;
      res_bad_r <= bad_r;
      res_sat_r <= !bad_r && sat_nxt;
    end
    if (cmd.out_load) begin
      out_r.counter_value <= cbmt_pkg::VAL_FIELD_W'(res_val_r);
      out_r.max_value     <= cbmt_pkg::VAL_FIELD_W'(max_r);
      out_r.max_holders   <= cbmt_pkg::HOLD_W'(holders_r);
      out_r.bad_index     <= res_bad_r;
      out_r.saturated     <= res_sat_r;
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/core/counter_bank_max_tracker_unit.sv -----
// Bank of COUNTERS signed saturating counters of COUNT_BITS bits with a live maximum. Each
// request increments, decrements, zeroes or reads one counter and returns its new value, the
// largest value among the active counters and how many of them hold it. Requests go one at a
// time through a read-modify-write of the counter memory and stall while an earlier result is
// not yet taken. When the only counter at the maximum moves off it, the active counters are
// swept at one counter per cycle. After reset and after every write of the active-count
// register the memory is cleared at one counter per cycle, and no request is taken meanwhile;
// register writes are always taken, and the user must keep them to idle periods, as the block
// itself does not enforce this. Counter values wider than 16 bits are reported by their low
// 16 bits.
module counter_bank_max_tracker_unit #(
  parameter int COUNTERS   = cbmt_pkg::DEF_COUNTERS,
  parameter int COUNT_BITS = cbmt_pkg::DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  cbmt_req_if.sink          in_ch,
  cbmt_rsp_if.source        out_ch,
  cbmt_cfg_if.sink          cfg_ch
);

  cbmt_pkg::cmd_t cmd;
  cbmt_pkg::sts_t sts;
  logic           cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  cbmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_fire  (cfg_fire),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbmt_dp #(
    .COUNTERS   (COUNTERS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_ch.data),
    .cfg_fire (cfg_fire),
    .cfg_data (cfg_ch.data),
    .out_data (out_ch.data)
  );

endmodule
